/* hdl/pes_pkg.sv */
// ----------------------------------------------------------------------------
// pes_pkg
// Shared widths, codes and controller/datapath handshake types for the
// packed element store.
// ----------------------------------------------------------------------------
`default_nettype none

package pes_pkg;

   localparam int WORD_BITS      = 64;
   localparam int OFF_BITS       = 6;
   localparam int INDEX_BITS     = 16;
   localparam int SIZE_BITS      = 7;
   localparam int COUNT_BITS     = 17;
   localparam int POS_BITS       = INDEX_BITS + SIZE_BITS;
   localparam int WORD_IDX_BITS  = POS_BITS - OFF_BITS;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [SIZE_BITS-1:0]  SIZE_RESET  = SIZE_BITS'(4);
   localparam logic [SIZE_BITS-1:0]  SIZE_MAX    = SIZE_BITS'(WORD_BITS);
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = '0;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ALPHABET_SIZE = 4'd0,
      CSR_ELEM_COUNT    = 4'd1
   } csr_index_type;

   typedef enum logic {
      ACT_READ  = 1'b0,
      ACT_WRITE = 1'b1
   } action_type;

   typedef enum logic {
      STAT_DONE  = 1'b0,
      STAT_RANGE = 1'b1
   } status_type;

   typedef struct packed {
      logic load;
      logic check;
      logic access;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic out_of_range;
   } stat_type;

endpackage

`default_nettype wire

/* hdl/pes_if.sv */
// ----------------------------------------------------------------------------
// pes_if
// Valid/ready channel interfaces: request, response and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface pes_req_if;
   logic                             valid;
   logic                             ready;
   logic                             action;
   logic [pes_pkg::INDEX_BITS-1:0]   elem_index;
   logic [pes_pkg::WORD_BITS-1:0]    elem_value;

   modport source (output valid, action, elem_index, elem_value, input ready);
   modport sink   (input valid, action, elem_index, elem_value, output ready);
endinterface

interface pes_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pes_pkg::WORD_BITS-1:0]    read_value;
   logic                             status;

   modport source (output valid, read_value, status, input ready);
   modport sink   (input valid, read_value, status, output ready);
endinterface

interface pes_csr_if;
   logic                                valid;
   logic                                ready;
   logic [pes_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [pes_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/pes_ram.sv */
// ----------------------------------------------------------------------------
// pes_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_ram #(
   parameter  int WIDTH = 64,
   parameter  int DEPTH = 512,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/pes_ctrl.sv */
// ----------------------------------------------------------------------------
// pes_ctrl
// Sequencer: accept, range check and bank read, read-modify-write, publish.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pes_pkg::cmd_type       cmd,
   input  wire pes_pkg::stat_type stat
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ACCESS,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.out_of_range ? ST_FINISH : ST_ACCESS;
         end
         ST_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* hdl/pes_datapath.sv */
// ----------------------------------------------------------------------------
// pes_datapath
// Registers, bit position math, even/odd word banks and element merge.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_datapath #(
   parameter int STORE_WORDS = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic [pes_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [pes_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  wire logic                                req_action,
   input  wire logic [pes_pkg::INDEX_BITS-1:0]      req_elem_index,
   input  wire logic [pes_pkg::WORD_BITS-1:0]       req_elem_value,
   input  wire pes_pkg::cmd_type                    cmd,
   output pes_pkg::stat_type                        stat,
   output logic [pes_pkg::WORD_BITS-1:0]            rsp_read_value,
   output logic                                     rsp_status
);

   localparam int WB         = pes_pkg::WORD_BITS;
   localparam int PB         = pes_pkg::POS_BITS;
   localparam int OB         = pes_pkg::OFF_BITS;
   localparam int SB         = pes_pkg::SIZE_BITS;
   localparam int XB         = pes_pkg::WORD_IDX_BITS;
   localparam int BANK_DEPTH = (STORE_WORDS + 1) / 2;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam logic [PB:0] CAP = (PB+1)'(STORE_WORDS * pes_pkg::WORD_BITS);

   logic [SB-1:0]                   asize_ff;
   logic [pes_pkg::COUNT_BITS-1:0]  count_ff;

   logic            action_ff;
   logic [SB-1:0]   width_ff;
   logic [PB-1:0]   bitpos_ff;
   logic [WB-1:0]   value_ff;
   logic            idx_oor_ff;
   logic            oor_ff;
   logic [WB-1:0]   res_value_ff;
   logic [WB-1:0]   out_value_ff;
   logic            out_status_ff;

   logic [SB-1:0]   width_in;
   logic [PB:0]     end_pos;
   logic            oor_now;
   logic [XB-1:0]   word;
   logic [OB-1:0]   off;
   logic [XB:0]     word_next;
   logic [BANK_AW-1:0] even_addr, odd_addr;
   logic [WB-1:0]   even_q, odd_q, lo_q, hi_q;
   logic [WB-1:0]   mask;
   logic [2*WB-1:0] pair, m_pair, v_pair, new_pair, shifted;
   logic [SB:0]     span;
   logic            spill;
   logic            lo_we, hi_we, even_we, odd_we;
   logic [WB-1:0]   even_wd, odd_wd, rd_val;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         asize_ff <= pes_pkg::SIZE_RESET;
         count_ff <= pes_pkg::COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            pes_pkg::CSR_ALPHABET_SIZE: asize_ff <= csr_data[SB-1:0];
            pes_pkg::CSR_ELEM_COUNT:    count_ff <= csr_data[pes_pkg::COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign width_in = (asize_ff > pes_pkg::SIZE_MAX) ? pes_pkg::SIZE_MAX : asize_ff;

   assign end_pos = {1'b0, bitpos_ff} + (PB+1)'(width_ff);
   assign oor_now = idx_oor_ff || (end_pos > CAP);
   assign stat.out_of_range = oor_now;

   assign word      = bitpos_ff[PB-1:OB];
   assign off       = bitpos_ff[OB-1:0];
   assign word_next = {1'b0, word} + (XB+1)'(1);
   assign even_addr = BANK_AW'(word_next >> 1);
   assign odd_addr  = BANK_AW'(word >> 1);

   assign lo_q = word[0] ? odd_q : even_q;
   assign hi_q = word[0] ? even_q : odd_q;

   assign mask     = (width_ff >= pes_pkg::SIZE_MAX) ? '1
                                                     : ((WB'(1) << width_ff) - WB'(1));
   assign pair     = {hi_q, lo_q};
   assign shifted  = pair >> off;
   assign rd_val   = shifted[WB-1:0] & mask;
   assign m_pair   = {{WB{1'b0}}, mask} << off;
   assign v_pair   = {{WB{1'b0}}, value_ff & mask} << off;
   assign new_pair = (pair & ~m_pair) | v_pair;
   assign span     = (SB+1)'(off) + (SB+1)'(width_ff);
   assign spill    = span > (SB+1)'(WB);

   assign lo_we   = cmd.access && (action_ff == pes_pkg::ACT_WRITE);
   assign hi_we   = lo_we && spill;
   assign even_we = word[0] ? hi_we : lo_we;
   assign odd_we  = word[0] ? lo_we : hi_we;
   assign even_wd = word[0] ? new_pair[2*WB-1:WB] : new_pair[WB-1:0];
   assign odd_wd  = word[0] ? new_pair[WB-1:0] : new_pair[2*WB-1:WB];

   pes_ram #(.WIDTH(WB), .DEPTH(BANK_DEPTH)) u_even_bank (
      .clock   (clock),
      .wr_en   (even_we),
      .addr    (even_addr),
      .wr_data (even_wd),
      .rd_data (even_q)
   );

   pes_ram #(.WIDTH(WB), .DEPTH(BANK_DEPTH)) u_odd_bank (
      .clock   (clock),
      .wr_en   (odd_we),
      .addr    (odd_addr),
      .wr_data (odd_wd),
      .rd_data (odd_q)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff  <= req_action;
         width_ff   <= width_in;
         bitpos_ff  <= PB'(req_elem_index) * PB'(width_in);
         value_ff   <= req_elem_value;
         idx_oor_ff <= ({1'b0, req_elem_index} >= count_ff);
      end
      if (cmd.check) begin
         oor_ff <= oor_now;
      end
      if (cmd.access) begin
         res_value_ff <= (action_ff == pes_pkg::ACT_WRITE) ? '0 : rd_val;
      end
      if (cmd.publish) begin
         out_value_ff  <= oor_ff ? '0 : res_value_ff;
         out_status_ff <= oor_ff ? pes_pkg::STAT_RANGE : pes_pkg::STAT_DONE;
      end
   end

   assign rsp_read_value = out_value_ff;
   assign rsp_status     = out_status_ff;

endmodule

`default_nettype wire

/* hdl/packed_element_store.sv */
// ----------------------------------------------------------------------------
// packed_element_store
// Bit-packed element array over 64-bit words with read and masked write.
// ----------------------------------------------------------------------------
// One request at a time. The index times width product is registered at the
// accepting edge. An in-range request then passes through the check state
// (range check while both candidate words are read), the access state (merge
// and read-modify-write) and the finish state (output register load); an
// out-of-range request skips the access state. The next transfer is taken
// once the controller is back in idle. Words are held in two single-port
// banks (even and odd word addresses) of (STORE_WORDS+1)/2 entries each, so
// both words of an element that straddles two words are read together and
// written together. Storage is not cleared by reset. A new request is taken
// while an earlier response is still waiting; its result is held in the
// finish state until the response register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_element_store #(
   parameter int STORE_WORDS = 1024
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pes_req_if.sink     req_chan,
   pes_rsp_if.source   rsp_chan,
   pes_csr_if.sink     csr_chan
);

   pes_pkg::cmd_type  cmd;
   pes_pkg::stat_type stat;

   assign csr_chan.ready = 1'b1;

   pes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   pes_datapath #(.STORE_WORDS(STORE_WORDS)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_chan.valid),
      .csr_index      (csr_chan.index),
      .csr_data       (csr_chan.data),
      .req_action     (req_chan.action),
      .req_elem_index (req_chan.elem_index),
      .req_elem_value (req_chan.elem_value),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_read_value (rsp_chan.read_value),
      .rsp_status     (rsp_chan.status)
   );

endmodule

`default_nettype wire

/* hdl/pes_checker.sv */
// ----------------------------------------------------------------------------
// pes_port_checks
// Port-level checks on the packed element store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_port_checks (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_ready,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   input  wire logic [pes_pkg::WORD_BITS-1:0]    rsp_read_value,
   input  wire logic                             rsp_status
);

   logic rsp_stall;

   assign rsp_stall = rsp_valid && !rsp_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_stall |=> rsp_valid)
      else $error("response dropped before transfer");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == pes_pkg::STAT_RANGE) |-> (rsp_read_value == '0))
      else $error("out-of-range response carries data");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one in flight");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised without work in progress");

endmodule

bind packed_element_store pes_port_checks u_pes_port_checks (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_read_value (rsp_chan.read_value),
   .rsp_status     (rsp_chan.status)
);

`default_nettype wire

/* test/pes_checker.sv */
// ----------------------------------------------------------------------------
// pes_checker
// Watches the request, response and register channels of the packed element
// store, keeps its own copy of the word store and the two registers, predicts
// one result per accepted request and compares each response field by field
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module pes_checker (
   input  wire logic clock,
   input  wire logic reset,
   pes_req_if        req_chan,
   pes_rsp_if        rsp_chan,
   pes_csr_if        csr_chan,
   output int        fail_count,
   output int        outstanding
);

   localparam int STORE_WORDS = 1024;
   localparam int STORE_BITS  = STORE_WORDS * pes_pkg::WORD_BITS;

   typedef struct packed {
      logic [pes_pkg::WORD_BITS-1:0] read_value;
      pes_pkg::status_type           status;
   } access_result_type;

   logic [pes_pkg::WORD_BITS-1:0]  words [STORE_WORDS];
   logic [pes_pkg::SIZE_BITS-1:0]  alpha_size;
   logic [pes_pkg::COUNT_BITS-1:0] elem_count;
   access_result_type              expected_results [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
      foreach (words[i]) words[i] = '0;
   end

   task automatic report_mismatch(string field, logic [pes_pkg::WORD_BITS-1:0] got,
                                  logic [pes_pkg::WORD_BITS-1:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
      fail_count++;
   endtask

   // Applies one access to the shadow store and returns the response it owes.
   function automatic access_result_type predict_access(pes_pkg::action_type act,
         logic [pes_pkg::INDEX_BITS-1:0] idx, logic [pes_pkg::WORD_BITS-1:0] val);
      int unsigned                   w, bitpos, word, off;
      bit                            spill;
      logic [pes_pkg::WORD_BITS-1:0] mask, data;
      access_result_type             res;
      w = (alpha_size > pes_pkg::SIZE_MAX) ? pes_pkg::WORD_BITS : alpha_size;
      bitpos = idx * w;
      res.read_value = '0;
      res.status = pes_pkg::STAT_DONE;
      if (idx >= elem_count || bitpos + w > STORE_BITS) begin
         res.status = pes_pkg::STAT_RANGE;
         return res;
      end
      mask = (w >= pes_pkg::WORD_BITS) ? '1 : (64'd1 << w) - 64'd1;
      word = bitpos / pes_pkg::WORD_BITS;
      off = bitpos % pes_pkg::WORD_BITS;
      spill = (off + w) > pes_pkg::WORD_BITS;
      if (act == pes_pkg::ACT_READ) begin
         data = words[word] >> off;
         if (spill)
            data |= words[word + 1] << (pes_pkg::WORD_BITS - off);
         res.read_value = data & mask;
      end else begin
         data = val & mask;
         words[word] = (words[word] & ~(mask << off)) | (data << off);
         if (spill)
            words[word + 1] = (words[word + 1] & ~(mask >> (pes_pkg::WORD_BITS - off)))
                              | (data >> (pes_pkg::WORD_BITS - off));
      end
      return res;
   endfunction

   always @(posedge clock) begin
      access_result_type want;
      if (reset) begin
         alpha_size <= pes_pkg::SIZE_RESET;
         elem_count <= pes_pkg::COUNT_RESET;
         expected_results.delete();
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               pes_pkg::CSR_ALPHABET_SIZE:
                  alpha_size <= csr_chan.data[pes_pkg::SIZE_BITS-1:0];
               pes_pkg::CSR_ELEM_COUNT:
                  elem_count <= csr_chan.data[pes_pkg::COUNT_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response", rsp_chan.read_value, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.status !== want.status)
                  report_mismatch("status", pes_pkg::WORD_BITS'(rsp_chan.status),
                                  pes_pkg::WORD_BITS'(want.status));
               if (rsp_chan.read_value !== want.read_value)
                  report_mismatch("read_value", rsp_chan.read_value, want.read_value);
            end
         end
         if (req_chan.valid && req_chan.ready)
            expected_results.push_back(
               predict_access(pes_pkg::action_type'(req_chan.action),
                              req_chan.elem_index, req_chan.elem_value));
      end
      outstanding <= expected_results.size();
   end

endmodule

/* test/tb_packed_element_store.sv */
// ----------------------------------------------------------------------------
// tb_packed_element_store
// Drives the packed element store with a short directed sequence covering
// register extremes, the zero and oversized element widths, out-of-range and
// past-the-store indexes and straddling elements, then random phases under
// varying register settings with random gaps on requests and responses.
// Reads only touch element bits that an earlier write has defined.
// ----------------------------------------------------------------------------

module tb_packed_element_store;

   localparam int          WORD_BITS    = pes_pkg::WORD_BITS;
   localparam int          STORE_WORDS  = 1024;
   localparam int          STORE_BITS   = STORE_WORDS * WORD_BITS;
   localparam int          PHASES       = 14;
   localparam int          PHASE_ITEMS  = 90;
   localparam int          DRAIN_CYCLES = 20;
   localparam int unsigned LIMIT_CYCLES = 600_000;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   outstanding;

   bit [WORD_BITS-1:0] known_bits [STORE_WORDS];
   int unsigned        cur_size;
   int unsigned        cur_count;
   bit                 steady;

   pes_req_if req_chan ();
   pes_rsp_if rsp_chan ();
   pes_csr_if csr_chan ();

   packed_element_store u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   pes_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_chan    (csr_chan),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned elem_width();
      return (cur_size > WORD_BITS) ? WORD_BITS : cur_size;
   endfunction

   // indexes below this are in range and inside the store
   function automatic int unsigned usable_count();
      int unsigned w, fit;
      w = elem_width();
      fit = (w == 0) ? 65536 : STORE_BITS / w;
      return (cur_count < fit) ? cur_count : fit;
   endfunction

   // mark: record a write; else report whether a read sees only defined bits
   function automatic bit track_element(int unsigned idx, bit mark);
      int unsigned w, pos;
      bit          all_known;
      w = elem_width();
      all_known = 1'b1;
      if (idx >= usable_count())
         return 1'b1;
      for (int b = 0; b < w; b++) begin
         pos = idx * w + b;
         if (mark)
            known_bits[pos / WORD_BITS][pos % WORD_BITS] = 1'b1;
         else if (!known_bits[pos / WORD_BITS][pos % WORD_BITS])
            all_known = 1'b0;
      end
      return all_known;
   endfunction

   task automatic issue(pes_pkg::action_type act, int unsigned idx,
                        logic [WORD_BITS-1:0] val);
      int unsigned gap;
      req_chan.valid      <= 1'b1;
      req_chan.action     <= act;
      req_chan.elem_index <= idx[pes_pkg::INDEX_BITS-1:0];
      req_chan.elem_value <= val;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (act == pes_pkg::ACT_WRITE)
         void'(track_element(idx, 1'b1));
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // both registers, only once every response is back
   task automatic set_config(int unsigned size, int unsigned count);
      logic [pes_pkg::CSR_DATA_BITS-1:0] junk;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      junk = $urandom;
      csr_chan.valid <= 1'b1;
      csr_chan.index <= pes_pkg::CSR_ALPHABET_SIZE;
      csr_chan.data  <= (junk & ~32'h7F) | size;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.index <= pes_pkg::CSR_ELEM_COUNT;
      csr_chan.data  <= (junk & ~32'h1FFFF) | count;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      cur_size  = size & 32'h7F;
      cur_count = count & 32'h1FFFF;
      @(posedge clock);
   endtask

   initial begin
      int unsigned run_len, stall;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= 1'b1;
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
         repeat (run_len) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end
      end
   end

   initial begin
      int unsigned          kind, size, count, n, r, idx, win_base, win_span;
      pes_pkg::action_type  act;
      logic [WORD_BITS-1:0] val;

      cur_size  = pes_pkg::SIZE_RESET;
      cur_count = pes_pkg::COUNT_RESET;
      steady    = 1'b0;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.action     <= pes_pkg::ACT_READ;
      req_chan.elem_index <= '0;
      req_chan.elem_value <= '0;
      csr_chan.valid      <= 1'b0;
      csr_chan.index      <= pes_pkg::CSR_ALPHABET_SIZE;
      csr_chan.data       <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // element count zero after reset: nothing is in range
      issue(pes_pkg::ACT_READ, 0, '0);
      issue(pes_pkg::ACT_WRITE, 65535, '1);

      set_config(64, 65536);
      issue(pes_pkg::ACT_WRITE, 0, '1);
      issue(pes_pkg::ACT_WRITE, 1023, 64'hA5A5_5A5A_0FF0_F00F);
      issue(pes_pkg::ACT_READ, 0, '0);
      issue(pes_pkg::ACT_READ, 1023, '0);
      issue(pes_pkg::ACT_WRITE, 1024, '1);
      issue(pes_pkg::ACT_READ, 65535, '0);

      set_config(1, 65536);
      issue(pes_pkg::ACT_WRITE, 65535, 64'hFFFF_FFFF_FFFF_FFFE);
      issue(pes_pkg::ACT_READ, 65535, '0);
      issue(pes_pkg::ACT_WRITE, 65534, '1);
      issue(pes_pkg::ACT_READ, 65534, '0);
      issue(pes_pkg::ACT_READ, 0, '0);

      // zero-width elements
      set_config(0, 65536);
      issue(pes_pkg::ACT_WRITE, 5, '1);
      issue(pes_pkg::ACT_READ, 65535, '0);

      // oversized width saturates to a full word
      set_config(127, 3);
      issue(pes_pkg::ACT_WRITE, 2, 64'h8000_0000_0000_0001);
      issue(pes_pkg::ACT_READ, 2, '0);
      issue(pes_pkg::ACT_READ, 3, '0);

      // element straddling words 0 and 1
      set_config(60, 100);
      issue(pes_pkg::ACT_WRITE, 1, 64'hFEDC_BA98_7654_3210);
      issue(pes_pkg::ACT_READ, 1, '0);
      issue(pes_pkg::ACT_READ, 0, '0);

      for (int k = 0; k < PHASES; k++) begin
         kind = (k < 5) ? k : $urandom_range(0, 9);
         case (kind)
            0: begin
               size  = 1;
               count = 65536;
            end
            1: begin
               size  = 64;
               count = $urandom_range(1000, 65536);
            end
            2: begin
               size  = 0;
               count = $urandom_range(1, 65536);
            end
            3: begin
               size  = $urandom_range(65, 127);
               count = $urandom_range(1, 300);
            end
            4: begin
               size  = $urandom_range(1, 64);
               count = 0;
            end
            default: begin
               size  = $urandom_range(1, 64);
               count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65536)
                                                   : $urandom_range(1, 200);
            end
         endcase
         set_config(size, count);
         n = usable_count();
         win_base = (n > 0) ? $urandom_range(0, n - 1) : 0;
         win_span = $urandom_range(0, 63);
         steady = ($urandom_range(0, 3) == 0);

         repeat (PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (n == 0 || r < 8)
               idx = $urandom_range(0, 65535);
            else if (r < 16)
               idx = $urandom_range(0, n - 1);
            else
               idx = (win_base + $urandom_range(0, win_span)) % n;
            act = ($urandom_range(0, 1) != 0) ? pes_pkg::ACT_WRITE : pes_pkg::ACT_READ;
            if (act == pes_pkg::ACT_READ && !track_element(idx, 1'b0))
               act = pes_pkg::ACT_WRITE;
            r = $urandom_range(0, 9);
            val = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
            issue(act, idx, val);
         end
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 8);
      $display("== FAIL ==");
      $finish;
   end

endmodule
